>>> rtl/base64_codec_unit_assert.svh
// assertion macros for the codec rtl
`ifndef BASE64_CODEC_UNIT_ASSERT_SVH
`define BASE64_CODEC_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64C_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define B64C_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/b64c_pkg.sv
package b64c_pkg;

    localparam int NumSlots = 4;

    localparam logic [7:0] PadChar = 8'h3d;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_message;
    } result_t;

    // all results caused by one input beat
    typedef result_t [NumSlots-1:0] burst_t;

    // group state carried between beats
    typedef struct packed {
        logic [17:0] bits;
        logic [1:0]  count;
        logic        stopped;
    } group_t;

    // sextet to alphabet character
    function automatic logic [7:0] b64c_char(input logic [5:0] v);
        logic [7:0] r;
        r = 8'h00;
        if (v < 6'd26)
            r = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            r = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            r = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            r = 8'h2b;
        else
            r = 8'h2f;
        return r;
    endfunction

    // character to sextet, bit 6 flags a non-alphabet character
    function automatic logic [6:0] b64c_sextet(input logic [7:0] ch);
        logic [6:0] r;
        r = 7'h40;
        if (ch >= 8'h41 && ch <= 8'h5a)
            r = {1'b0, 6'(ch - 8'h41)};
        else if (ch >= 8'h61 && ch <= 8'h7a)
            r = {1'b0, 6'(ch - 8'h61 + 8'd26)};
        else if (ch >= 8'h30 && ch <= 8'h39)
            r = {1'b0, 6'(ch - 8'h30 + 8'd52)};
        else if (ch == 8'h2b)
            r = 7'd62;
        else if (ch == 8'h2f)
            r = 7'd63;
        return r;
    endfunction

endpackage

>>> rtl/b64c_step.sv
module b64c_step (
    input  logic             mode,
    input  b64c_pkg::group_t cur,
    input  logic [7:0]       data_byte,
    input  logic             last_item,
    output b64c_pkg::group_t nxt,
    output b64c_pkg::burst_t res,
    output logic [2:0]       res_cnt
);
    import b64c_pkg::*;

    logic [6:0]  sext;
    logic [23:0] word;
    logic [23:0] fword;

    assign sext = b64c_sextet(data_byte);

    // next group state and the results of one beat
    always_comb
    begin
        nxt     = cur;
        res     = '0;
        res_cnt = 3'd0;
        word    = '0;
        fword   = '0;
        if (mode == MODE_ENCODE)
        begin
            // collect bytes, emit four characters on a full group
            if (cur.count < 2'd2)
            begin
                nxt.bits  = {2'b00, cur.bits[7:0], data_byte};
                nxt.count = cur.count + 2'd1;
            end
            else
            begin
                word = {cur.bits[15:0], data_byte};
                for (int i = 0; i < NumSlots; i++)
                begin
                    res[i].out_byte   = b64c_char(word[23-6*i -: 6]);
                    res[i].byte_valid = 1'b1;
                end
                res_cnt   = 3'd4;
                nxt.bits  = '0;
                nxt.count = 2'd0;
            end
            // partial group flush with padding
            if (last_item && nxt.count != 2'd0)
            begin
                fword = (nxt.count == 2'd1) ? {nxt.bits[7:0], 16'h0000}
                                            : {nxt.bits[15:0], 8'h00};
                for (int i = 0; i < NumSlots; i++)
                begin
                    res[i].out_byte   = (3'(i) <= {1'b0, nxt.count}) ?
                                        b64c_char(fword[23-6*i -: 6]) : PadChar;
                    res[i].byte_valid = 1'b1;
                end
                res_cnt = 3'd4;
            end
        end
        else
        begin
            // collect sextets until the first pad or foreign character
            if (!cur.stopped)
            begin
                if (sext[6])
                    nxt.stopped = 1'b1;
                else if (cur.count < 2'd3)
                begin
                    nxt.bits  = {cur.bits[11:0], sext[5:0]};
                    nxt.count = cur.count + 2'd1;
                end
                else
                begin
                    word = {cur.bits, sext[5:0]};
                    for (int i = 0; i < 3; i++)
                    begin
                        res[i].out_byte   = word[23-8*i -: 8];
                        res[i].byte_valid = 1'b1;
                    end
                    res_cnt   = 3'd3;
                    nxt.bits  = '0;
                    nxt.count = 2'd0;
                end
            end
            // partial group flush
            if (last_item && nxt.count >= 2'd2)
            begin
                fword = (nxt.count == 2'd2) ? {nxt.bits[11:0], 12'h000}
                                            : {nxt.bits, 6'h00};
                res[0].out_byte   = fword[23:16];
                res[0].byte_valid = 1'b1;
                res[1].out_byte   = fword[15:8];
                res[1].byte_valid = 1'b1;
                res_cnt = (nxt.count == 2'd2) ? 3'd1 : 3'd2;
            end
        end
        // end mark and group clear on the last beat
        if (last_item)
        begin
            if (res_cnt == 3'd0)
            begin
                res[0]  = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_message: 1'b1};
                res_cnt = 3'd1;
            end
            else
                res[2'(res_cnt - 3'd1)].end_of_message = 1'b1;
            nxt = '0;
        end
    end

endmodule

>>> rtl/base64_codec_unit.sv
// Streaming Base64 codec, standard alphabet with '=' padding. codec_mode 0 encodes
// bytes into characters, 1 decodes characters into bytes; writing codec_mode also
// drops any partial group. Every input beat is held in an input register, then
// resolved in a single pass into a burst of up to four result beats that is handed
// out one beat per cycle while result_stall is low. Beats with no result retire
// without waiting on the result port, so encode takes bytes as a burst drains and
// decode one character per cycle while result_stall is low; the result port sets the
// rate. With the result port free, an input beat passes the input register, then the
// burst register, before its first result beat is presented. A last_item beat always
// closes with end_of_message, on an empty marker with byte_valid 0 if needed.
module base64_codec_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       codec_mode_we,
    input  logic       codec_mode,
    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] data_byte,
    input  logic       last_item,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       end_of_message
);
    import b64c_pkg::*;

    logic       mode_reg;
    group_t     group_reg;
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    burst_t     burst_reg;
    logic [2:0] burst_cnt_reg;
    logic [1:0] rd_idx_reg;

    group_t     step_grp;
    burst_t     step_res;
    logic [2:0] step_cnt;
    logic       accept, advance, pop, pop_last;
    result_t    cur_res;

    // single-pass group logic
    b64c_step u_step (
        .mode      (mode_reg),
        .cur       (group_reg),
        .data_byte (in_byte_reg),
        .last_item (in_last_reg),
        .nxt       (step_grp),
        .res       (step_res),
        .res_cnt   (step_cnt)
    );

    // handshake
    assign result_valid = (burst_cnt_reg != 3'd0);
    assign pop          = result_valid && !result_stall;
    assign pop_last     = pop && ({1'b0, rd_idx_reg} == burst_cnt_reg - 3'd1);
    assign advance      = in_vld_reg &&
                          (step_cnt == 3'd0 || burst_cnt_reg == 3'd0 || pop_last);
    assign data_stall   = in_vld_reg && !advance;
    assign accept       = data_valid && !data_stall;
    assign in_vld_next  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);

    // output beat
    assign cur_res        = burst_reg[rd_idx_reg];
    assign out_byte       = cur_res.out_byte;
    assign byte_valid     = cur_res.byte_valid;
    assign end_of_message = cur_res.end_of_message;

    // mode, group state and input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ENCODE;
            group_reg  <= '0;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (codec_mode_we)
            begin
                mode_reg  <= codec_mode;
                group_reg <= '0;
            end
            else if (advance)
                group_reg <= step_grp;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_item;
        end
    end

    // burst control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_cnt_reg <= 3'd0;
            rd_idx_reg    <= 2'd0;
        end
        else if (advance && step_cnt != 3'd0)
        begin
            burst_cnt_reg <= step_cnt;
            rd_idx_reg    <= 2'd0;
        end
        else if (pop_last)
        begin
            burst_cnt_reg <= 3'd0;
            rd_idx_reg    <= 2'd0;
        end
        else if (pop)
            rd_idx_reg <= rd_idx_reg + 2'd1;
    end

    // burst payload
    always_ff @(posedge clk)
    begin
        if (advance && step_cnt != 3'd0)
            burst_reg <= step_res;
    end

`include "base64_codec_unit_assert.svh"

    `B64C_ASSERT_NOW(a_idx_in_burst, result_valid, {1'b0, rd_idx_reg} < burst_cnt_reg, "read index past burst")
    `B64C_ASSERT_NOW(a_eom_at_tail, result_valid && end_of_message, {1'b0, rd_idx_reg} == burst_cnt_reg - 3'd1, "end mark not on final beat")
    `B64C_ASSERT_NOW(a_empty_is_eom, result_valid && !byte_valid, end_of_message, "empty beat without end mark")
    `B64C_ASSERT_NEXT(a_clear_after_last, advance && in_last_reg && !codec_mode_we, group_reg == '0, "group not cleared after last beat")
    `B64C_ASSERT_NEXT(a_hold_pending, in_vld_reg && !advance, in_vld_reg, "pending input beat lost")

endmodule
